/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define RWL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define RWL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/rwl_pkg.sv */
package rwl_pkg;

  localparam int unsigned TID_W    = 8;
  localparam int unsigned RC_W     = 9;
  localparam int unsigned STATUS_W = 3;
  localparam logic [RC_W-1:0] MAX_READERS = 9'd256;

  typedef enum logic [1:0] {
    OP_READ_LOCK    = 2'd0,
    OP_READ_UNLOCK  = 2'd1,
    OP_WRITE_LOCK   = 2'd2,
    OP_WRITE_UNLOCK = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_MISUSE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD    = 2'd0,
    CNT_INC_SAT = 2'd1,
    CNT_DEC     = 2'd2
  } cnt_op_t;

  typedef struct packed {
    logic is_zero;
    logic is_one;
    logic at_max;
  } cnt_stat_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one;
  } q_stat_t;

endpackage

/* hdl/rwl_req_if.sv */
interface rwl_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [rwl_pkg::TID_W-1:0] tid;

  modport source (output valid, op, tid, input ready);
  modport sink   (input valid, op, tid, output ready);
endinterface

/* hdl/rwl_rsp_if.sv */
interface rwl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rwl_pkg::STATUS_W-1:0] status;
  logic                        woken_valid;
  logic [rwl_pkg::TID_W-1:0]    woken_tid;
  logic                        woken_as_writer;
  logic [rwl_pkg::RC_W-1:0]     active_readers;
  logic                        last;

  modport source (output valid, status, woken_valid, woken_tid, woken_as_writer,
                  active_readers, last, input ready);
  modport sink   (input valid, status, woken_valid, woken_tid, woken_as_writer,
                  active_readers, last, output ready);
endinterface

/* hdl/rwl_cnt_unit.sv */
module rwl_cnt_unit (
  input  logic [rwl_pkg::RC_W-1:0] count,
  input  rwl_pkg::cnt_op_t         op,
  output logic [rwl_pkg::RC_W-1:0] result,
  output rwl_pkg::cnt_stat_t       stat
);

  always_comb begin
    stat.is_zero = (count == '0);
    stat.is_one  = (count == rwl_pkg::RC_W'(1));
    stat.at_max  = (count >= rwl_pkg::MAX_READERS);
    case (op)
      rwl_pkg::CNT_HOLD:    result = count;
      rwl_pkg::CNT_INC_SAT: result = stat.at_max ? count : count + rwl_pkg::RC_W'(1);
      rwl_pkg::CNT_DEC:     result = count - rwl_pkg::RC_W'(1);
      default:              result = count;
    endcase
  end

endmodule

/* hdl/rwl_wait_q.sv */
module rwl_wait_q #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [rwl_pkg::TID_W-1:0] push_data,
  input  logic                      pop,
  output logic [rwl_pkg::TID_W-1:0] head_data,
  output rwl_pkg::q_stat_t          stat
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [rwl_pkg::TID_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  head, head_next, tail, tail_next, rd_addr;
  logic [FILL_W-1:0] fill, fill_next;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (pop) begin
      head_next = (head == LAST_PTR) ? '0 : head + PTR_W'(1);
      fill_next = fill_next - FILL_W'(1);
    end
    if (push) begin
      tail_next = (tail == LAST_PTR) ? '0 : tail + PTR_W'(1);
      fill_next = fill_next + FILL_W'(1);
    end
    rd_addr    = head_next;
    stat.empty = (fill == '0);
    stat.full  = (fill == FILL_W'(DEPTH));
    stat.one   = (fill == FILL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    head_data <= mem[rd_addr];
  end

endmodule

/* hdl/reader_writer_lock_manager_core.sv */
// A request is accepted in S_IDLE and captured on the move to S_EXEC; in S_EXEC, once the
// result slot is free, its result is registered.
// A write release that wakes N queued readers goes on to S_DRAIN, which gives one result
// per cycle, N in all; a result that waits holds the block for as long as it waits.
// A new request is taken only in S_IDLE, once the last one's results have all been registered.
// Reset (rst, synchronous): no reader, no writer, both wait queues empty.
`include "assert_macros.svh"

module reader_writer_lock_manager_core #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  rwl_req_if.sink   req,
  rwl_rsp_if.source rsp
);

  rwl_pkg::state_t state, state_next;

  rwl_pkg::op_t               req_op;
  logic [rwl_pkg::TID_W-1:0]  req_tid;

  logic [rwl_pkg::RC_W-1:0]   reader_count, reader_count_next;
  logic                       writer_held, writer_held_next;
  logic [rwl_pkg::TID_W-1:0]  writer_id, writer_id_next;

  logic                       rsp_valid;
  rwl_pkg::status_t           rsp_status;
  logic                       rsp_woken_valid;
  logic [rwl_pkg::TID_W-1:0]  rsp_woken_tid;
  logic                       rsp_woken_as_writer;
  logic [rwl_pkg::RC_W-1:0]   rsp_active_readers;
  logic                       rsp_last;

  logic                       emit, slot_free;
  rwl_pkg::status_t           e_status;
  logic                       e_wv, e_ww, e_last;
  logic [rwl_pkg::TID_W-1:0]  e_wt;

  rwl_pkg::cnt_op_t           cnt_op;
  logic [rwl_pkg::RC_W-1:0]   cnt_res;
  rwl_pkg::cnt_stat_t         cnt_stat;

  logic                       rq_push, rq_pop, wq_push, wq_pop;
  logic [rwl_pkg::TID_W-1:0]  rq_data, wq_data;
  rwl_pkg::q_stat_t           rq_stat, wq_stat;

  rwl_cnt_unit u_cnt (
    .count  (reader_count),
    .op     (cnt_op),
    .result (cnt_res),
    .stat   (cnt_stat)
  );

  rwl_wait_q #(.DEPTH(QUEUE_DEPTH)) u_read_q (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (req_tid),
    .pop       (rq_pop),
    .head_data (rq_data),
    .stat      (rq_stat)
  );

  rwl_wait_q #(.DEPTH(QUEUE_DEPTH)) u_write_q (
    .clk       (clk),
    .rst       (rst),
    .push      (wq_push),
    .push_data (req_tid),
    .pop       (wq_pop),
    .head_data (wq_data),
    .stat      (wq_stat)
  );

  assign req.ready = (state == rwl_pkg::S_IDLE);
  assign slot_free = !rsp_valid || rsp.ready;

  always_comb begin
    state_next        = state;
    reader_count_next = cnt_res;
    writer_held_next  = writer_held;
    writer_id_next    = writer_id;
    cnt_op            = rwl_pkg::CNT_HOLD;
    emit              = 1'b0;
    e_status          = rwl_pkg::ST_GRANTED;
    e_wv              = 1'b0;
    e_wt              = '0;
    e_ww              = 1'b0;
    e_last            = 1'b1;
    rq_push           = 1'b0;
    rq_pop            = 1'b0;
    wq_push           = 1'b0;
    wq_pop            = 1'b0;
    case (state)
      rwl_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = rwl_pkg::S_EXEC;
        end
      end
      rwl_pkg::S_EXEC: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = rwl_pkg::S_IDLE;
          case (req_op)
            rwl_pkg::OP_READ_LOCK: begin
              if (!writer_held && wq_stat.empty) begin
                if (cnt_stat.at_max) begin
                  e_status = rwl_pkg::ST_FULL;
                end else begin
                  cnt_op   = rwl_pkg::CNT_INC_SAT;
                  e_status = rwl_pkg::ST_GRANTED;
                end
              end else if (rq_stat.full) begin
                e_status = rwl_pkg::ST_FULL;
              end else begin
                rq_push  = 1'b1;
                e_status = rwl_pkg::ST_QUEUED;
              end
            end
            rwl_pkg::OP_READ_UNLOCK: begin
              if (cnt_stat.is_zero) begin
                e_status = rwl_pkg::ST_MISUSE;
              end else begin
                cnt_op   = rwl_pkg::CNT_DEC;
                e_status = rwl_pkg::ST_RELEASED;
                if (cnt_stat.is_one && !wq_stat.empty) begin
                  wq_pop           = 1'b1;
                  writer_held_next = 1'b1;
                  writer_id_next   = wq_data;
                  e_wv             = 1'b1;
                  e_wt             = wq_data;
                  e_ww             = 1'b1;
                end
              end
            end
            rwl_pkg::OP_WRITE_LOCK: begin
              if (cnt_stat.is_zero && !writer_held) begin
                writer_held_next = 1'b1;
                writer_id_next   = req_tid;
                e_status         = rwl_pkg::ST_GRANTED;
              end else if (wq_stat.full) begin
                e_status = rwl_pkg::ST_FULL;
              end else begin
                wq_push  = 1'b1;
                e_status = rwl_pkg::ST_QUEUED;
              end
            end
            rwl_pkg::OP_WRITE_UNLOCK: begin
              if (!writer_held) begin
                e_status = rwl_pkg::ST_MISUSE;
              end else begin
                writer_held_next = 1'b0;
                writer_id_next   = '0;
                e_status         = rwl_pkg::ST_RELEASED;
                if (!rq_stat.empty) begin
                  emit       = 1'b0;
                  state_next = rwl_pkg::S_DRAIN;
                end else if (cnt_stat.is_zero && !wq_stat.empty) begin
                  wq_pop           = 1'b1;
                  writer_held_next = 1'b1;
                  writer_id_next   = wq_data;
                  e_wv             = 1'b1;
                  e_wt             = wq_data;
                  e_ww             = 1'b1;
                end
              end
            end
            default: begin
              e_status = rwl_pkg::ST_MISUSE;
            end
          endcase
        end
      end
      rwl_pkg::S_DRAIN: begin
        if (slot_free) begin
          emit     = 1'b1;
          rq_pop   = 1'b1;
          cnt_op   = rwl_pkg::CNT_INC_SAT;
          e_status = rwl_pkg::ST_RELEASED;
          e_wv     = 1'b1;
          e_wt     = rq_data;
          e_last   = rq_stat.one;
          if (rq_stat.one) begin
            state_next = rwl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = rwl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rwl_pkg::S_IDLE;
      reader_count <= '0;
      writer_held  <= 1'b0;
      writer_id    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      reader_count <= reader_count_next;
      writer_held  <= writer_held_next;
      writer_id    <= writer_id_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_op  <= rwl_pkg::op_t'(req.op);
      req_tid <= req.tid;
    end
    if (emit) begin
      rsp_status          <= e_status;
      rsp_woken_valid     <= e_wv;
      rsp_woken_tid       <= e_wt;
      rsp_woken_as_writer <= e_ww;
      rsp_active_readers  <= reader_count_next;
      rsp_last            <= e_last;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.woken_valid     = rsp_woken_valid;
  assign rsp.woken_tid       = rsp_woken_tid;
  assign rsp.woken_as_writer = rsp_woken_as_writer;
  assign rsp.active_readers  = rsp_active_readers;
  assign rsp.last            = rsp_last;

  `RWL_ASSERT_ALWAYS(a_rc_bound, reader_count <= rwl_pkg::MAX_READERS, "reader count overflow")
  `RWL_ASSERT_IMP(a_excl, writer_held, reader_count == '0, "writer and readers both hold")
  `RWL_ASSERT_IMP(a_drain_src, state == rwl_pkg::S_DRAIN, !rq_stat.empty, "drain on empty queue")
  `RWL_ASSERT_IMP(a_rd_wait, (state == rwl_pkg::S_IDLE) && !rq_stat.empty,
                  writer_held || !wq_stat.empty, "readers wait with no cause")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rwl_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDLE_LIMIT = 1000;

  typedef struct packed {
    status_t           status;
    logic              woken_valid;
    logic [TID_W-1:0]  woken_tid;
    logic              woken_as_writer;
    logic [RC_W-1:0]   active_readers;
    logic              last;
  } lock_result_t;

  class lock_scoreboard;
    int unsigned      depth;
    logic [RC_W-1:0]  readers;
    bit               writer_busy;
    logic [TID_W-1:0] owner;
    logic [TID_W-1:0] read_waiters[$];
    logic [TID_W-1:0] write_waiters[$];
    lock_result_t     expected_results[$];
    int unsigned      failures;

    function new(int unsigned d);
      depth = d;
      readers = '0;
      writer_busy = 0;
      owner = '0;
      failures = 0;
    endfunction

    function void add_result(status_t s, bit wv, logic [TID_W-1:0] wt, bit ww, bit fin);
      lock_result_t r;
      r.status = s;
      r.woken_valid = wv;
      r.woken_tid = wt;
      r.woken_as_writer = ww;
      r.active_readers = readers;
      r.last = fin;
      expected_results.push_back(r);
    endfunction

    function void hand_to_writer();
      owner = write_waiters.pop_front();
      writer_busy = 1;
      add_result(ST_RELEASED, 1, owner, 1, 1);
    endfunction

    function void predict_request(op_t op, logic [TID_W-1:0] tid);
      logic [TID_W-1:0] woken;
      case (op)
        OP_READ_LOCK: begin
          if (!writer_busy && write_waiters.size() == 0) begin
            if (readers >= MAX_READERS) begin
              add_result(ST_FULL, 0, '0, 0, 1);
            end else begin
              readers++;
              add_result(ST_GRANTED, 0, '0, 0, 1);
            end
          end else if (read_waiters.size() < depth) begin
            read_waiters.push_back(tid);
            add_result(ST_QUEUED, 0, '0, 0, 1);
          end else begin
            add_result(ST_FULL, 0, '0, 0, 1);
          end
        end
        OP_READ_UNLOCK: begin
          if (readers == 0) begin
            add_result(ST_MISUSE, 0, '0, 0, 1);
          end else begin
            readers--;
            if (readers == 0 && write_waiters.size() != 0) hand_to_writer();
            else add_result(ST_RELEASED, 0, '0, 0, 1);
          end
        end
        OP_WRITE_LOCK: begin
          if (readers == 0 && !writer_busy) begin
            writer_busy = 1;
            owner = tid;
            add_result(ST_GRANTED, 0, '0, 0, 1);
          end else if (write_waiters.size() < depth) begin
            write_waiters.push_back(tid);
            add_result(ST_QUEUED, 0, '0, 0, 1);
          end else begin
            add_result(ST_FULL, 0, '0, 0, 1);
          end
        end
        default: begin
          if (!writer_busy) begin
            add_result(ST_MISUSE, 0, '0, 0, 1);
          end else begin
            writer_busy = 0;
            owner = '0;
            if (read_waiters.size() != 0) begin
              while (read_waiters.size() != 0) begin
                woken = read_waiters.pop_front();
                if (readers < MAX_READERS) readers++;
                add_result(ST_RELEASED, 1, woken, 0, read_waiters.size() == 0);
              end
            end else if (readers == 0 && write_waiters.size() != 0) begin
              hand_to_writer();
            end else begin
              add_result(ST_RELEASED, 0, '0, 0, 1);
            end
          end
        end
      endcase
    endfunction

    function void check_response(lock_result_t got);
      lock_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d woken=%0d/%0h writer=%0d readers=%0d last=%0d",
                 $time, got.status, got.woken_valid, got.woken_tid, got.woken_as_writer,
                 got.active_readers, got.last);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected status=%0d woken=%0d/%0h writer=%0d readers=%0d last=%0d",
                 $time, want.status, want.woken_valid, want.woken_tid, want.woken_as_writer,
                 want.active_readers, want.last);
        $display("%0t:          actual status=%0d woken=%0d/%0h writer=%0d readers=%0d last=%0d",
                 $time, got.status, got.woken_valid, got.woken_tid, got.woken_as_writer,
                 got.active_readers, got.last);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  rwl_req_if req_bus ();
  rwl_rsp_if rsp_bus ();

  lock_scoreboard board;
  int unsigned    burst_left;
  int unsigned    idle_cycles;
  logic [31:0]    rx_cycle = '0;
  logic [1:0]     rx_mode = 2'd0;
  lock_result_t   seen;

  reader_writer_lock_manager_core #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: stall pattern picked at random from four modes and changed from time to time
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 50 == 0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: rsp_bus.ready <= 1'b1;
      2'd1: rsp_bus.ready <= rx_cycle[0];
      2'd2: rsp_bus.ready <= (rx_cycle[1:0] == 2'd0);
      default: rsp_bus.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      seen.status = status_t'(rsp_bus.status);
      seen.woken_valid = rsp_bus.woken_valid;
      seen.woken_tid = rsp_bus.woken_tid;
      seen.woken_as_writer = rsp_bus.woken_as_writer;
      seen.active_readers = rsp_bus.active_readers;
      seen.last = rsp_bus.last;
      board.check_response(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               board.expected_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(op_t op, logic [TID_W-1:0] tid);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        req_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.tid <= tid;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    board.predict_request(op, tid);
  endtask

  task automatic flood(op_t op, int unsigned count);
    repeat (count) send_request(op, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
  endtask

  // mostly legal lock/unlock traffic, with some arbitrary requests mixed in
  task automatic send_random_request();
    int unsigned pick;
    logic [TID_W-1:0] tid;
    pick = $urandom_range(0, 99);
    tid = 8'($urandom_range(0, 255));
    if (pick < 8) send_request(op_t'($urandom_range(0, 3)), tid);
    else if (board.writer_busy && pick < 35) send_request(OP_WRITE_UNLOCK, tid);
    else if (board.readers != 0 && pick < 60) send_request(OP_READ_UNLOCK, tid);
    else if (pick < 82) send_request(OP_READ_LOCK, tid);
    else send_request(OP_WRITE_LOCK, tid);
  endtask

  initial begin
    board = new(DEPTH);
    burst_left = 0;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.op = OP_READ_LOCK;
    req_bus.tid = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_request(OP_WRITE_UNLOCK, 8'hFF);
    send_request(OP_READ_UNLOCK, 8'h00);
    send_request(OP_WRITE_LOCK, 8'h00);
    send_request(OP_WRITE_UNLOCK, 8'h00);
    send_request(OP_READ_LOCK, 8'h00);
    send_request(OP_READ_LOCK, 8'hFF);
    send_request(OP_WRITE_LOCK, 8'hAA);
    send_request(OP_READ_LOCK, 8'h55);
    send_request(OP_WRITE_LOCK, 8'h5A);
    send_request(OP_READ_UNLOCK, 8'h00);
    send_request(OP_READ_UNLOCK, 8'hFF);
    send_request(OP_READ_LOCK, 8'h33);
    send_request(OP_WRITE_UNLOCK, 8'hAA);
    send_request(OP_READ_UNLOCK, 8'h55);
    send_request(OP_READ_UNLOCK, 8'h33);
    send_request(OP_WRITE_UNLOCK, 8'h5A);
    send_request(OP_WRITE_LOCK, 8'h01);
    send_request(OP_WRITE_LOCK, 8'h80);
    send_request(OP_WRITE_UNLOCK, 8'h01);
    send_request(OP_WRITE_UNLOCK, 8'h80);

    // random traffic with writer and reader queue overflows
    for (int i = 0; i < 180; i++) begin
      if (i % 60 == 30) wait_for_results();
      if (i == 40) flood(OP_WRITE_LOCK, 35);
      if (i == 100) begin
        send_request(OP_WRITE_LOCK, 8'($urandom_range(0, 255)));
        flood(OP_READ_LOCK, 34);
      end
      send_random_request();
    end

    wait_for_results();
    repeat (16) @(posedge clk);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
